[rtl/hrmm_pkg.sv]
// Package with payload types, register indexes and sequencer states for the histogram min/max block.
package hrmm_pkg;

    typedef struct packed {
        logic signed [31:0] sample;
        logic [7:0]         point_label;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] range_min;
        logic signed [31:0] range_max;
        logic [1:0]         status;
        logic               buckets_saturated;
    } t_out_item;

    localparam logic [2:0] REG_STEP      = 3'd0;
    localparam logic [2:0] REG_MIN_COUNT = 3'd1;
    localparam logic [2:0] REG_LBL_EN    = 3'd2;
    localparam logic [2:0] REG_TARGET    = 3'd3;
    localparam logic [2:0] REG_PRIOR_MIN = 3'd4;
    localparam logic [2:0] REG_PRIOR_MAX = 3'd5;

    localparam logic [1:0] ST_FOUND   = 2'd0;
    localparam logic [1:0] ST_NO_PAIR = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    typedef enum logic [3:0] {
        S_LOAD,
        S_DIV,
        S_CLR,
        S_RD,
        S_RDW,
        S_IDX,
        S_UPD,
        S_SCAN_RD,
        S_SCAN_W,
        S_SCAN,
        S_PICK_RD,
        S_PICK_W,
        S_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [32:0] dividend;
        logic [30:0] divisor;
    } t_div_req;

endpackage

[rtl/hrmm_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
module hrmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/hrmm_div.sv]
// Restoring bit-serial divider: 33-bit unsigned dividend over 31-bit divisor.
module hrmm_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hrmm_pkg::t_div_req   i_req,
    output logic                 o_done,
    output logic [32:0]          o_quot
);
    import hrmm_pkg::*;

    logic [32:0] r_quot, n_quot;
    logic [31:0] r_rem, n_rem;
    logic [30:0] r_dvs, n_dvs;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] w_trial;

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem, r_quot[32]};
        if (i_req.start) begin
            n_quot = i_req.dividend;
            n_rem  = '0;
            n_dvs  = (i_req.divisor == '0) ? 31'd1 : i_req.divisor;
            n_cnt  = 6'd33;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {2'b00, r_dvs}) begin
                n_rem  = 32'(w_trial - {2'b00, r_dvs});
                n_quot = {r_quot[31:0], 1'b1};
            end else begin
                n_rem  = w_trial[31:0];
                n_quot = {r_quot[31:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

[rtl/histogram_robust_min_max.sv]
// Top level of the histogram trimmed min/max block: loader, sequencer and bucket stores.
// After the last load beat it divides the span to size the buckets, clears every bucket count,
// bins each used sample offset on the shared serial divider, scans the active buckets and
// picks the result; an empty set goes straight to the result.
// Throughput: one beat per cycle while loading, none until the result is registered.
// Reset (synchronous, active low) restores defaults, empties the set, drops any result.
module histogram_robust_min_max #(
    parameter int MAX_POINTS  = 4096,
    parameter int NUM_BUCKETS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  hrmm_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output hrmm_pkg::t_out_item  o_item,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    import hrmm_pkg::*;

    localparam int PW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int BW = $clog2(NUM_BUCKETS);
    localparam int NW = $clog2(NUM_BUCKETS + 1);

    // Configuration registers.
    logic [30:0]        r_step;
    logic [12:0]        r_min_count;
    logic               r_lbl_en;
    logic [7:0]         r_target;
    logic signed [31:0] r_prior_min, r_prior_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= 31'd32768;
            r_min_count <= '0;
            r_lbl_en    <= 1'b0;
            r_target    <= '0;
            r_prior_min <= 32'sh7FFFFFFF;
            r_prior_max <= 32'sh80000000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_STEP:      r_step      <= i_cfg_data[30:0];
                REG_MIN_COUNT: r_min_count <= i_cfg_data[12:0];
                REG_LBL_EN:    r_lbl_en    <= i_cfg_data[0];
                REG_TARGET:    r_target    <= i_cfg_data[7:0];
                REG_PRIOR_MIN: r_prior_min <= i_cfg_data;
                REG_PRIOR_MAX: r_prior_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer state and datapath registers.
    t_state             r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;        // used samples in the set
    logic signed [31:0] r_rmin, n_rmin, r_rmax, n_rmax;
    logic [CW-1:0]      r_k, n_k;            // sample walk pointer
    logic [NW-1:0]      r_b, n_b;            // bucket walk pointer
    logic [NW-1:0]      r_nb, n_nb;          // active bucket count
    logic               r_sat, n_sat;
    logic [NW-1:0]      r_first, n_first, r_lastb, n_lastb;
    logic               r_ffound, n_ffound;
    logic signed [31:0] r_v, n_v;
    logic [BW-1:0]      r_idx, n_idx;
    logic               r_ov, n_ov;
    // The result is built in r_res and moved to the output register once that is free,
    // so a result still waiting downstream is never overwritten.
    t_out_item          r_res, n_res;
    t_out_item          r_out, n_out;

    // Memories.
    logic              w_s_we;
    logic [PW-1:0]     w_s_waddr, w_s_raddr;
    logic [31:0]       w_s_rdata;
    logic              w_c_we, w_e_we;
    logic [BW-1:0]     w_b_waddr, w_b_raddr;
    logic [12:0]       w_c_wdata, w_c_rdata;
    logic [63:0]       w_e_wdata, w_e_rdata;

    hrmm_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_samples (
        .i_clk(i_clk), .i_we(w_s_we), .i_waddr(w_s_waddr), .i_wdata(i_item.sample),
        .i_raddr(w_s_raddr), .o_rdata(w_s_rdata));
    hrmm_ram #(.WIDTH(13), .DEPTH(NUM_BUCKETS)) u_counts (
        .i_clk(i_clk), .i_we(w_c_we), .i_waddr(w_b_waddr), .i_wdata(w_c_wdata),
        .i_raddr(w_b_raddr), .o_rdata(w_c_rdata));
    hrmm_ram #(.WIDTH(64), .DEPTH(NUM_BUCKETS)) u_extremes (
        .i_clk(i_clk), .i_we(w_e_we), .i_waddr(w_b_waddr), .i_wdata(w_e_wdata),
        .i_raddr(w_b_raddr), .o_rdata(w_e_rdata));

    // Shared divider: span for the bucket count, then each sample offset.
    t_div_req    w_div;
    logic        w_div_done;
    logic [32:0] w_quot;

    hrmm_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_div), .o_done(w_div_done),
        .o_quot(w_quot));

    logic w_use, w_acc;
    logic signed [31:0] w_lo, w_hi;
    assign w_use = !r_lbl_en || (i_item.point_label == r_target);
    assign w_acc = i_valid && o_ready;
    assign w_lo  = w_e_rdata[63:32];
    assign w_hi  = w_e_rdata[31:0];

    always_comb begin
        n_state = r_state;  n_cnt = r_cnt;   n_rmin = r_rmin;  n_rmax = r_rmax;
        n_k = r_k;          n_b = r_b;       n_nb = r_nb;      n_sat = r_sat;
        n_first = r_first;  n_lastb = r_lastb; n_ffound = r_ffound;
        n_v = r_v;          n_idx = r_idx;   n_ov = r_ov;      n_out = r_out;
        n_res = r_res;
        o_ready = 1'b0;
        w_s_we = 1'b0;  w_s_waddr = r_cnt[PW-1:0];  w_s_raddr = r_k[PW-1:0];
        w_c_we = 1'b0;  w_e_we = 1'b0;
        w_b_waddr = r_idx;  w_b_raddr = r_b[BW-1:0];
        w_c_wdata = '0;  w_e_wdata = {r_v, r_v};
        w_div.start = 1'b0;
        w_div.dividend = 33'({r_rmax[31], r_rmax} - {r_rmin[31], r_rmin});
        w_div.divisor = r_step;

        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_LOAD: begin
                o_ready = 1'b1;
                if (w_acc) begin
                    // Samples past the store capacity are dropped entirely.
                    if (w_use && r_cnt < CW'(MAX_POINTS)) begin
                        w_s_we = 1'b1;
                        n_cnt = r_cnt + 1'b1;
                        if (i_item.sample < r_rmin) n_rmin = i_item.sample;
                        if (i_item.sample > r_rmax) n_rmax = i_item.sample;
                    end
                    if (i_item.last) begin
                        n_state = S_DIV;
                        w_div.start = 1'b1;
                        if (w_use && r_cnt < CW'(MAX_POINTS)) begin
                            w_div.dividend = 33'({n_rmax[31], n_rmax} - {n_rmin[31], n_rmin});
                        end
                        if (n_cnt == '0) begin
                            n_res.range_min = r_prior_min;
                            n_res.range_max = r_prior_max;
                            n_res.status = ST_EMPTY;
                            n_res.buckets_saturated = 1'b0;
                            n_state = S_OUT;
                        end
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    if (w_quot >= 33'(NUM_BUCKETS)) begin
                        n_nb = NW'(NUM_BUCKETS);
                        n_sat = 1'b1;
                    end else begin
                        n_nb = NW'(w_quot + 33'd1);
                        n_sat = 1'b0;
                    end
                    n_b = '0;
                    n_state = S_CLR;
                end
            end
            S_CLR: begin
                w_c_we = 1'b1;
                w_b_waddr = r_b[BW-1:0];
                w_c_wdata = '0;
                n_b = r_b + 1'b1;
                if (r_b == NW'(NUM_BUCKETS - 1)) begin
                    n_k = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_RDW;
            end
            S_RDW: begin
                n_v = w_s_rdata;
                w_div.start = 1'b1;
                w_div.dividend = 33'({w_s_rdata[31], w_s_rdata} - {r_rmin[31], r_rmin});
                n_state = S_IDX;
            end
            S_IDX: begin
                if (w_div_done) begin
                    if (w_quot > 33'(r_nb - 1'b1)) n_idx = BW'(r_nb - 1'b1);
                    else n_idx = w_quot[BW-1:0];
                    n_state = S_UPD;
                end
                w_b_raddr = n_idx;
            end
            S_UPD: begin
                w_c_we = 1'b1;
                w_e_we = 1'b1;
                w_c_wdata = w_c_rdata + 13'd1;
                if (w_c_rdata != '0) begin
                    w_e_wdata = {(r_v < w_lo) ? r_v : w_lo, (r_v > w_hi) ? r_v : w_hi};
                end
                n_k = r_k + 1'b1;
                n_state = (n_k == r_cnt) ? S_SCAN_RD : S_RD;
                n_b = '0;
                n_ffound = 1'b0;
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_W;
            end
            S_SCAN_W: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // Count of bucket r_b is on the read port here.
                if (w_c_rdata > r_min_count) begin
                    if (!r_ffound) n_first = r_b;
                    n_ffound = 1'b1;
                    n_lastb = r_b;
                end
                n_b = r_b + 1'b1;
                w_b_raddr = n_b[BW-1:0];
                n_state = (n_b == r_nb) ? S_PICK_RD : S_SCAN_W;
            end
            S_PICK_RD: begin
                n_res.range_min = r_prior_min;
                n_res.range_max = r_prior_max;
                n_res.buckets_saturated = r_sat;
                if (r_ffound && r_first < r_lastb) begin
                    n_res.status = ST_FOUND;
                    w_b_raddr = r_first[BW-1:0];
                    n_b = r_lastb;
                    n_state = S_PICK_W;
                end else begin
                    n_res.status = ST_NO_PAIR;
                    n_state = S_OUT;
                end
            end
            S_PICK_W: begin
                // Low bucket data arrives on the first pass; high bucket on the second.
                w_b_raddr = r_b[BW-1:0];
                if (!r_ffound) begin
                    if (w_hi > r_res.range_max) n_res.range_max = w_hi;
                    n_state = S_OUT;
                end else begin
                    if (w_lo < r_res.range_min) n_res.range_min = w_lo;
                    n_ffound = 1'b0;
                end
            end
            S_OUT: begin
                // Wait until the output register is empty or being emptied.
                if (!r_ov || i_ready) begin
                    n_ov = 1'b1;
                    n_out = r_res;
                    n_cnt = '0;
                    n_rmin = 32'sh7FFFFFFF;
                    n_rmax = 32'sh80000000;
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_rmin  <= 32'sh7FFFFFFF;
            r_rmax  <= 32'sh80000000;
            r_ov    <= 1'b0;
            r_ffound <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rmin  <= n_rmin;
            r_rmax  <= n_rmax;
            r_ov    <= n_ov;
            r_ffound <= n_ffound;
        end
        r_k <= n_k;  r_b <= n_b;  r_nb <= n_nb;  r_sat <= n_sat;
        r_first <= n_first;  r_lastb <= n_lastb;
        r_v <= n_v;  r_idx <= n_idx;  r_out <= n_out;  r_res <= n_res;
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;
endmodule
